FILE: hdl/pal_pkg.sv
// shared types and constants for the positional array list unit
`timescale 1ns / 1ps

package pal_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int MODE_W    = 2;
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int FPOS_W    = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_SEARCH  = 2'd2,
        MODE_DISPLAY = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic    load;
        t_op     op;
        logic    idx_clr;
        logic    idx_inc;
        logic    emit;
        t_status status;
        logic    sel_cell;
        logic    sel_pos_idx;
        logic    last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  pos_ok_ins;
        logic  pos_ok_del;
        logic  hit;
        logic  at_end;
    } t_stat;

endpackage

FILE: hdl/pal_ctrl.sv
// controller state machine of the positional array list unit
`timescale 1ns / 1ps

module pal_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pal_pkg::t_stat i_stat,
    output pal_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    pal_pkg::t_state r_state;
    pal_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.op          = pal_pkg::OP_NONE;
        o_cmd.status      = pal_pkg::ST_OK;
        o_busy            = 1'b1;
        unique case (r_state)
            pal_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = pal_pkg::S_DECIDE;
                end
            end
            pal_pkg::S_DECIDE: begin
                unique case (i_stat.mode)
                    pal_pkg::MODE_INSERT: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.status = pal_pkg::ST_FULL;
                        end else if (!i_stat.pos_ok_ins) begin
                            o_cmd.status = pal_pkg::ST_BADPOS;
                        end else begin
                            o_cmd.op = pal_pkg::OP_INSERT;
                        end
                        n_state = pal_pkg::S_IDLE;
                    end
                    pal_pkg::MODE_DELETE: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        if (i_stat.empty) begin
                            o_cmd.status = pal_pkg::ST_EMPTY;
                        end else if (!i_stat.pos_ok_del) begin
                            o_cmd.status = pal_pkg::ST_BADPOS;
                        end else begin
                            // removed value is read before the shift lands
                            o_cmd.op       = pal_pkg::OP_DELETE;
                            o_cmd.sel_cell = 1'b1;
                        end
                        n_state = pal_pkg::S_IDLE;
                    end
                    pal_pkg::MODE_SEARCH, pal_pkg::MODE_DISPLAY: begin
                        if (i_stat.empty) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.last   = 1'b1;
                            o_cmd.status = pal_pkg::ST_EMPTY;
                            n_state      = pal_pkg::S_IDLE;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = pal_pkg::S_SCAN;
                        end
                    end
                    default: n_state = pal_pkg::S_IDLE;
                endcase
            end
            pal_pkg::S_SCAN: begin
                if (i_stat.mode == pal_pkg::MODE_SEARCH) begin
                    if (i_stat.hit) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.last        = 1'b1;
                        o_cmd.sel_cell    = 1'b1;
                        o_cmd.sel_pos_idx = 1'b1;
                        n_state           = pal_pkg::S_IDLE;
                    end else if (i_stat.at_end) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.last   = 1'b1;
                        o_cmd.status = pal_pkg::ST_NOTFOUND;
                        n_state      = pal_pkg::S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end else begin
                    // display: one transfer per entry
                    o_cmd.emit        = 1'b1;
                    o_cmd.sel_cell    = 1'b1;
                    o_cmd.sel_pos_idx = 1'b1;
                    o_cmd.last        = i_stat.at_end;
                    if (i_stat.at_end) begin
                        n_state = pal_pkg::S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: n_state = pal_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: hdl/pal_datapath.sv
// datapath of the positional array list unit: cells, count, scan index, result register
`timescale 1ns / 1ps

module pal_datapath #(
    parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [pal_pkg::MODE_W-1:0]         i_mode,
    input  logic [pal_pkg::POS_W-1:0]          i_position,
    input  logic signed [pal_pkg::DATA_W-1:0]  i_value,
    input  pal_pkg::t_cmd                      i_cmd,
    output pal_pkg::t_stat                     o_stat,
    output logic                               o_strobe,
    output logic [pal_pkg::STATUS_W-1:0]       o_status,
    output logic [pal_pkg::FPOS_W-1:0]         o_found_position,
    output logic signed [pal_pkg::DATA_W-1:0]  o_data_out,
    output logic                               o_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W;

    logic [pal_pkg::DATA_W-1:0]   r_cells [DEPTH];
    logic [CNT_W-1:0]             r_count;
    logic [IDX_W-1:0]             r_idx;
    logic [pal_pkg::POS_W-1:0]    r_pos;
    logic [pal_pkg::DATA_W-1:0]   r_value;
    pal_pkg::t_mode               r_mode;

    logic                         r_strobe;
    logic [pal_pkg::STATUS_W-1:0] r_status;
    logic [pal_pkg::FPOS_W-1:0]   r_fpos;
    logic [pal_pkg::DATA_W-1:0]   r_data;
    logic                         r_last;

    logic [pal_pkg::DATA_W-1:0]   cell_rd;
    logic [IDX_W+pal_pkg::FPOS_W-1:0] idx_ext;

    assign cell_rd = r_cells[r_idx];
    assign idx_ext = {{pal_pkg::FPOS_W{1'b0}}, r_idx};

    assign o_stat.mode       = r_mode;
    assign o_stat.full       = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.pos_ok_ins = (CMP_W'(r_pos) <= CMP_W'(r_count));
    assign o_stat.pos_ok_del = (CMP_W'(r_pos) <  CMP_W'(r_count));
    assign o_stat.hit        = (cell_rd == r_value);
    assign o_stat.at_end     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // request registers and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= pal_pkg::t_mode'(i_mode);
            r_pos   <= i_position;
            r_value <= i_value;
            // delete reads its entry at the requested position
            r_idx   <= IDX_W'(i_position);
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.op == pal_pkg::OP_INSERT) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.op == pal_pkg::OP_DELETE) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // cells above the index (insert) or at and above it (delete) shift from their neighbor at once
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_cmd.op == pal_pkg::OP_INSERT) begin
                if (IDX_W'(i) == r_idx) begin
                    r_cells[i] <= r_value;
                end else if ((i > 0) && (IDX_W'(i) > r_idx)) begin
                    r_cells[i] <= r_cells[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.op == pal_pkg::OP_DELETE) begin
                if ((i < DEPTH - 1) && (IDX_W'(i) >= r_idx)) begin
                    r_cells[i] <= r_cells[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            r_fpos   <= i_cmd.sel_pos_idx ? idx_ext[pal_pkg::FPOS_W-1:0] : '0;
            r_data   <= i_cmd.sel_cell ? cell_rd : '0;
            r_last   <= i_cmd.last;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_found_position = r_fpos;
    assign o_data_out       = r_data;
    assign o_last           = r_last;

endmodule

FILE: hdl/positional_array_list_unit.sv
// top level of the positional array list unit
// insert and delete give one registered transfer from the decide state; a new request is taken only back in idle
// search scans one entry a cycle through the shared read mux, up to count entries
// display streams count transfers on back-to-back cycles after the decide state
// empty-list and refused requests answer with a single transfer from the decide state; results cannot be stalled
// synchronous reset empties the list; entry contents stay undefined until written
`timescale 1ns / 1ps

module positional_array_list_unit #(
    parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pal_pkg::MODE_W-1:0]         i_mode,
    input  logic [pal_pkg::POS_W-1:0]          i_position,
    input  logic signed [pal_pkg::DATA_W-1:0]  i_value,
    output logic                               o_busy,
    output logic                               o_strobe,
    output logic [pal_pkg::STATUS_W-1:0]       o_status,
    output logic [pal_pkg::FPOS_W-1:0]         o_found_position,
    output logic signed [pal_pkg::DATA_W-1:0]  o_data_out,
    output logic                               o_last
);

    pal_pkg::t_cmd  cmd;
    pal_pkg::t_stat stat;

    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    pal_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (i_mode),
        .i_position       (i_position),
        .i_value          (i_value),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_data_out       (o_data_out),
        .o_last           (o_last)
    );

endmodule

FILE: hdl/pal_checker.sv
// port-level checks for the positional array list unit and their bind
`timescale 1ns / 1ps

module pal_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_strobe,
    input logic [pal_pkg::STATUS_W-1:0]  o_status,
    input logic                          o_last
);

    // an accepted request keeps the unit busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("unit not busy after accepted request");

    // a display stream has no gaps until its last transfer
    a_stream_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap in result stream");

    // any status other than ok ends the request
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != pal_pkg::ST_OK)) |-> o_last)
        else $error("error result not marked last");

    // after the final transfer the unit is free again
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !o_busy)
        else $error("unit still busy after final result");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_status (o_status),
    .o_last   (o_last)
);
